>>> rtl/ssienc_pkg.sv
// Shared constants and codes for the SSI encoder reader with offset.
package ssienc_pkg;

  localparam int unsigned JOINTS_DEFAULT        = 2;
  localparam int unsigned POSITION_BITS_DEFAULT = 12;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned HALF_W     = 8;
  localparam int unsigned FRAME_W    = 6;
  localparam int unsigned OPCODE_W   = 3;

  localparam logic [HALF_W-1:0]  HALF_PERIOD_RESET = 8'd5;
  localparam logic [FRAME_W-1:0] FRAME_LEN_RESET   = 6'd18;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 3'd0,
    OP_READ  = 3'd1,
    OP_ZERO  = 3'd2,
    OP_LOAD  = 3'd3,
    OP_QUERY = 3'd4
  } opcode_e;

  typedef enum logic {
    CFG_HALF_PERIOD = 1'b0,
    CFG_FRAME_LEN   = 1'b1
  } cfg_reg_e;

endpackage

>>> rtl/ssienc_core.sv
// Frame sequencer, offset table and results for one item per in_fire_i cycle.
module ssienc_core #(
  parameter int unsigned JOINTS        = ssienc_pkg::JOINTS_DEFAULT,
  parameter int unsigned POSITION_BITS = ssienc_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [ssienc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                                in_fire_i,
  input  logic [ssienc_pkg::OPCODE_W-1:0]     opcode_i,
  input  logic                                joint_i,
  input  logic [POSITION_BITS-1:0]            offset_value_i,
  input  logic                                data_line_i,
  output logic                                sensor_clock_o,
  output logic [JOINTS-1:0]                   select_n_o,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [POSITION_BITS-1:0]            raw_o,
  output logic [POSITION_BITS-1:0]            pos_o,
  output logic [POSITION_BITS-1:0]            offset_o,
  output logic                                rejected_o
);

  localparam int unsigned JointIdxW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  logic [ssienc_pkg::HALF_W-1:0]  half_period_q;
  logic [ssienc_pkg::FRAME_W-1:0] frame_len_q;

  logic [POSITION_BITS-1:0]       offsets_q [JOINTS];
  logic [POSITION_BITS-1:0]       offsets_d [JOINTS];
  logic [POSITION_BITS-1:0]       shift_q, shift_d;
  logic [ssienc_pkg::FRAME_W-1:0] pulse_q, pulse_d;
  logic [ssienc_pkg::HALF_W-1:0]  div_q, div_d;
  logic                           clk_lvl_q, clk_lvl_d;
  logic                           active_q, active_d;
  logic [JointIdxW-1:0]           joint_q, joint_d;
  logic                           zero_q, zero_d;

  logic                           is_cmd;
  logic                           joint_ok;
  logic [JointIdxW-1:0]           jidx;
  logic [ssienc_pkg::HALF_W-1:0]  div_inc;
  logic [ssienc_pkg::FRAME_W-1:0] pulse_inc;
  logic [POSITION_BITS-1:0]       shift_set;
  logic [POSITION_BITS-1:0]       raw_new;

  assign joint_ok  = (32'(joint_i) < JOINTS);
  assign jidx      = JointIdxW'(joint_i);
  assign div_inc   = div_q + 8'd1;
  assign pulse_inc = pulse_q + 6'd1;

  always_comb begin
    unique case (opcode_i) inside
      ssienc_pkg::OP_READ, ssienc_pkg::OP_ZERO,
      ssienc_pkg::OP_LOAD, ssienc_pkg::OP_QUERY: is_cmd = 1'b1;
      default: is_cmd = 1'b0;
    endcase
  end

  // MSB first: pulse n lands in bit POSITION_BITS-1-n
  always_comb begin
    shift_set = '0;
    for (int k = 0; k < POSITION_BITS; k++) begin
      shift_set[k] = data_line_i && (pulse_q == 6'(POSITION_BITS - 1 - k));
    end
  end

  assign raw_new = shift_q | shift_set;

  always_comb begin
    offsets_d  = offsets_q;
    shift_d    = shift_q;
    pulse_d    = pulse_q;
    div_d      = div_q;
    clk_lvl_d  = clk_lvl_q;
    active_d   = active_q;
    joint_d    = joint_q;
    zero_d     = zero_q;
    done_o     = 1'b0;
    raw_o      = '0;
    pos_o      = '0;
    offset_o   = '0;
    rejected_o = 1'b0;

    if (active_q) begin
      rejected_o = is_cmd;
      if (div_inc >= half_period_q) begin
        div_d = '0;
        if (!clk_lvl_q) begin
          clk_lvl_d = 1'b1;
        end else begin
          shift_d = raw_new;
          pulse_d = pulse_inc;
          if (pulse_inc >= frame_len_q) begin
            active_d = 1'b0;
            done_o   = 1'b1;
            raw_o    = raw_new;
            if (zero_q) begin
              offsets_d[joint_q] = raw_new;
              pos_o              = '0;
            end else begin
              pos_o = raw_new - offsets_q[joint_q];
            end
          end else begin
            clk_lvl_d = 1'b0;
          end
        end
      end else begin
        div_d = div_inc;
      end
    end else if (is_cmd) begin
      if (!joint_ok) begin
        rejected_o = 1'b1;
      end else begin
        unique case (opcode_i) inside
          ssienc_pkg::OP_READ, ssienc_pkg::OP_ZERO: begin
            active_d  = 1'b1;
            joint_d   = jidx;
            zero_d    = (opcode_i == ssienc_pkg::OP_ZERO);
            shift_d   = '0;
            pulse_d   = '0;
            div_d     = '0;
            clk_lvl_d = 1'b0;
          end
          ssienc_pkg::OP_LOAD: offsets_d[jidx] = offset_value_i;
          default: offset_o = offsets_q[jidx];
        endcase
      end
    end
  end

  assign sensor_clock_o = clk_lvl_d;
  assign busy_o         = active_d;

  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      select_n_o[j] = !(active_d && (joint_d == JointIdxW'(j)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= ssienc_pkg::HALF_PERIOD_RESET;
      frame_len_q   <= ssienc_pkg::FRAME_LEN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ssienc_pkg::CFG_HALF_PERIOD) begin
        half_period_q <= cfg_data_i;
      end else begin
        frame_len_q <= cfg_data_i[ssienc_pkg::FRAME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < JOINTS; j++) begin
        offsets_q[j] <= '1;
      end
      shift_q   <= '0;
      pulse_q   <= '0;
      div_q     <= '0;
      clk_lvl_q <= 1'b1;
      active_q  <= 1'b0;
      joint_q   <= '0;
      zero_q    <= 1'b0;
    end else if (in_fire_i) begin
      offsets_q <= offsets_d;
      shift_q   <= shift_d;
      pulse_q   <= pulse_d;
      div_q     <= div_d;
      clk_lvl_q <= clk_lvl_d;
      active_q  <= active_d;
      joint_q   <= joint_d;
      zero_q    <= zero_d;
    end
  end

endmodule

>>> rtl/ssienc_out_reg.sv
// Result register with valid/ready; refills in the cycle it is drained.
module ssienc_out_reg #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             valid_q, valid_d;
  logic [WIDTH-1:0] data_q;
  logic             load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign data_o      = data_q;

endmodule

>>> rtl/ssi_encoder_reader_with_offset_top.sv
// Top level of the SSI absolute encoder reader with per-joint offsets.
//
// Input channel (in_valid_i/in_ready_o): each transfer is one item, either a
// divider tick or a command (read, zero capture, load offset, query offset)
// for one joint. data_line_i carries the sensor data pin level for that item.
// Output channel (out_valid_o/out_ready_i): exactly one result transfer per
// input item, in order: pin levels (sensor clock, active-low selects), busy,
// done, raw reading, offset-corrected position, queried offset, rejected.
// The result of an item accepted at a clock edge is held in the result
// register and offered from that edge onward. Throughput is one item per cycle
// while the receiver keeps up, set by the single result register; a new item
// is taken in the same cycle the held result is transferred.
// If the receiver stalls, the result register holds its value and in_ready_o
// drops until it is taken; frame state does not advance. Reset: no frame
// active, sensor clock high, all selects high, offsets all ones, half period
// 5 ticks, frame length 18 pulses. Configuration (cfg_we_i, cfg_idx_i,
// cfg_data_i) must be written only while idle; the block does not enforce it.
module ssi_encoder_reader_with_offset_top #(
  parameter int unsigned JOINTS        = ssienc_pkg::JOINTS_DEFAULT,
  parameter int unsigned POSITION_BITS = ssienc_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [ssienc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // item channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ssienc_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic                               joint_i,
  input  logic [POSITION_BITS-1:0]           offset_value_i,
  input  logic                               data_line_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               sensor_clock_o,
  output logic [JOINTS-1:0]                  select_n_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [POSITION_BITS-1:0]           raw_reading_o,
  output logic [POSITION_BITS-1:0]           position_o,
  output logic [POSITION_BITS-1:0]           offset_out_o,
  output logic                               rejected_o
);

  // packed result: clock, selects, busy, done, raw, position, offset, rejected
  localparam int unsigned ResW = 4 + JOINTS + 3 * POSITION_BITS;

  logic                     in_fire;
  logic                     sclk;
  logic [JOINTS-1:0]        sel_n;
  logic                     busy;
  logic                     done;
  logic [POSITION_BITS-1:0] raw;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] offs;
  logic                     rej;
  logic [ResW-1:0]          res_d;
  logic [ResW-1:0]          res_q;

  // state advances only on an accepted transfer
  assign in_fire = in_valid_i && in_ready_o;

  ssienc_core #(
    .JOINTS       (JOINTS),
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_fire_i     (in_fire),
    .opcode_i      (opcode_i),
    .joint_i       (joint_i),
    .offset_value_i(offset_value_i),
    .data_line_i   (data_line_i),
    .sensor_clock_o(sclk),
    .select_n_o    (sel_n),
    .busy_o        (busy),
    .done_o        (done),
    .raw_o         (raw),
    .pos_o         (pos),
    .offset_o      (offs),
    .rejected_o    (rej)
  );

  assign res_d = {sclk, sel_n, busy, done, raw, pos, offs, rej};

  ssienc_out_reg #(
    .WIDTH(ResW)
  ) u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_i     (res_d),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_o     (res_q)
  );

  assign {sensor_clock_o, select_n_o, busy_res_o, done_res_o,
          raw_reading_o, position_o, offset_out_o, rejected_o} = res_q;

endmodule
